// ===== src/greedy_threshold_match_count_unit_defines.svh =====
// Assertion macros shared by the RTL.
`ifndef GREEDY_THRESHOLD_MATCH_COUNT_UNIT_DEFINES_SVH
`define GREEDY_THRESHOLD_MATCH_COUNT_UNIT_DEFINES_SVH

// same-cycle implication
`define GTMC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define GTMC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== src/gtmc_pkg.sv =====
`default_nettype none
package gtmc_pkg;
    localparam int MAX_ITEMS_DEF  = 256;
    localparam int VALUE_BITS_DEF = 31;

    localparam logic [1:0] OP_LOAD_DEMAND = 2'd0;
    localparam logic [1:0] OP_LOAD_SUPPLY = 2'd1;
    localparam logic [1:0] OP_RUN         = 2'd2;

    typedef struct packed {
        logic [1:0]  op;
        logic [30:0] value;
    } t_in_beat;

    typedef struct packed {
        logic [8:0] match_count;
        logic       load_dropped;
    } t_out_beat;
endpackage
`default_nettype wire

// ===== src/gtmc_list_mem.sv =====
`default_nettype none
module gtmc_list_mem #(
    parameter int DEPTH = 256,
    parameter int W     = 31
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire [$clog2(DEPTH)-1:0]  i_waddr,
    input  wire [W-1:0]              i_wdata,
    input  wire                      i_re,
    input  wire [$clog2(DEPTH)-1:0]  i_raddr,
    output logic [W-1:0]             o_rdata
);
    logic [W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

// ===== src/gtmc_cmp.sv =====
`default_nettype none
module gtmc_cmp #(
    parameter int W = 31
) (
    input  wire [W-1:0] i_a,
    input  wire [W-1:0] i_b,
    output logic        o_gt
);
    // unsigned a > b, shared by insertion and matching
    assign o_gt = (i_a > i_b);
endmodule
`default_nettype wire

// ===== src/greedy_threshold_match_count_unit.sv =====
// Greedy matching of a demand list against a supply list.
// Input channel (i_in_valid / o_in_stall, payload i_in): op 0 loads a demand,
// op 1 loads a supply, op 2 runs the match and clears both lists, op 3 is
// ignored. A beat is taken when valid is high and stall is low.
// Loads are kept sorted by insertion: the new value walks down the list,
// one entry at a time (read, then compare and write), through the
// list memory port and the single shared comparator. A load into a full
// list only sets the dropped flag.
// A run walks both lists from the top, a read and a compare per demand
// visited, then emits one result beat on the output channel
// (o_out_valid / i_out_stall, payload o_out).
// The result sits in an output register; loads may be taken while it waits.
// A second run that finishes while the receiver still stalls waits in its
// final state until the register frees. The input stalls while busy.
// Reset empties both lists, clears the dropped flag and drops any pending
// result. List memories are not cleared: entries above the counts are
// never read.
`default_nettype none
`include "greedy_threshold_match_count_unit_defines.svh"
module greedy_threshold_match_count_unit
    import gtmc_pkg::*;
#(
    parameter int MAX_ITEMS  = MAX_ITEMS_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  wire       i_clk,
    input  wire       i_rst_n,
    input  wire       i_in_valid,
    output logic      o_in_stall,
    input  t_in_beat  i_in,
    output logic      o_out_valid,
    input  wire       i_out_stall,
    output t_out_beat o_out
);
    localparam int AW = $clog2(MAX_ITEMS);
    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam logic [CW-1:0] FULL = CW'(MAX_ITEMS);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_INS_RD  = 3'd1;
    localparam logic [2:0] S_INS_CMP = 3'd2;
    localparam logic [2:0] S_RUN_RD  = 3'd3;
    localparam logic [2:0] S_RUN_CMP = 3'd4;
    localparam logic [2:0] S_RUN_OUT = 3'd5;

    logic [2:0]            r_state, n_state;
    logic [CW-1:0]         r_dcnt, n_dcnt, r_scnt, n_scnt;
    logic                  r_ovf, n_ovf, r_ovf_run, n_ovf_run;
    logic                  r_sel, n_sel;          // 1: supply list
    logic [CW-1:0]         r_pos, n_pos;          // insertion slot / demand index
    logic [CW-1:0]         r_si, n_si;
    logic [CW-1:0]         r_pairs, n_pairs;
    logic [VALUE_BITS-1:0] r_val, n_val;
    logic                  r_out_valid, n_out_valid;
    t_out_beat             r_out, n_out;

    logic                  w_acc, w_gt;
    logic [VALUE_BITS-1:0] w_inval, w_d_rdata, w_s_rdata, w_cmp_a, w_cmp_b, w_wdata;
    logic                  w_d_we, w_s_we, w_d_re, w_s_re;
    logic [AW-1:0]         w_d_raddr, w_s_raddr, w_waddr;
    logic [CW-1:0]         w_pos_m1, w_si_m1;

    assign w_acc    = i_in_valid && !o_in_stall;
    assign w_inval  = VALUE_BITS'(i_in.value);
    assign w_pos_m1 = r_pos - 1'b1;
    assign w_si_m1  = r_si - 1'b1;
    assign w_waddr  = r_pos[AW-1:0];

    // one comparator: insertion tests entry > new value, run tests demand > supply
    assign w_cmp_a = (r_state == S_RUN_CMP || !r_sel) ? w_d_rdata : w_s_rdata;
    assign w_cmp_b = (r_state == S_RUN_CMP) ? w_s_rdata : r_val;

    gtmc_cmp #(.W(VALUE_BITS)) u_cmp (
        .i_a  (w_cmp_a),
        .i_b  (w_cmp_b),
        .o_gt (w_gt)
    );

    gtmc_list_mem #(.DEPTH(MAX_ITEMS), .W(VALUE_BITS)) u_demand (
        .i_clk   (i_clk),
        .i_we    (w_d_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_d_re),
        .i_raddr (w_d_raddr),
        .o_rdata (w_d_rdata)
    );

    gtmc_list_mem #(.DEPTH(MAX_ITEMS), .W(VALUE_BITS)) u_supply (
        .i_clk   (i_clk),
        .i_we    (w_s_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_s_re),
        .i_raddr (w_s_raddr),
        .o_rdata (w_s_rdata)
    );

    always_comb begin
        n_state     = r_state;
        n_dcnt      = r_dcnt;
        n_scnt      = r_scnt;
        n_ovf       = r_ovf;
        n_ovf_run   = r_ovf_run;
        n_sel       = r_sel;
        n_pos       = r_pos;
        n_si        = r_si;
        n_pairs     = r_pairs;
        n_val       = r_val;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        w_d_we      = 1'b0;
        w_s_we      = 1'b0;
        w_d_re      = 1'b0;
        w_s_re      = 1'b0;
        w_wdata     = r_val;
        w_d_raddr   = w_pos_m1[AW-1:0];
        w_s_raddr   = (r_state == S_RUN_RD) ? w_si_m1[AW-1:0] : w_pos_m1[AW-1:0];

        case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    n_val = w_inval;
                    case (i_in.op)
                        OP_LOAD_DEMAND: begin
                            if (r_dcnt == FULL) begin
                                n_ovf = 1'b1;
                            end else begin
                                n_sel   = 1'b0;
                                n_pos   = r_dcnt;
                                n_dcnt  = r_dcnt + 1'b1;
                                n_state = S_INS_RD;
                            end
                        end
                        OP_LOAD_SUPPLY: begin
                            if (r_scnt == FULL) begin
                                n_ovf = 1'b1;
                            end else begin
                                n_sel   = 1'b1;
                                n_pos   = r_scnt;
                                n_scnt  = r_scnt + 1'b1;
                                n_state = S_INS_RD;
                            end
                        end
                        OP_RUN: begin
                            n_pos     = r_dcnt;
                            n_si      = r_scnt;
                            n_pairs   = '0;
                            n_ovf_run = r_ovf;
                            n_dcnt    = '0;
                            n_scnt    = '0;
                            n_ovf     = 1'b0;
                            n_state   = S_RUN_RD;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_INS_RD: begin
                if (r_pos == '0) begin
                    w_d_we  = !r_sel;
                    w_s_we  = r_sel;
                    n_state = S_IDLE;
                end else begin
                    w_d_re  = !r_sel;
                    w_s_re  = r_sel;
                    n_state = S_INS_CMP;
                end
            end
            S_INS_CMP: begin
                w_d_we = !r_sel;
                w_s_we = r_sel;
                if (w_gt) begin
                    // shift the larger entry up one slot
                    w_wdata = r_sel ? w_s_rdata : w_d_rdata;
                    n_pos   = w_pos_m1;
                    n_state = S_INS_RD;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_RUN_RD: begin
                if (r_pos == '0 || r_si == '0) begin
                    n_state = S_RUN_OUT;
                end else begin
                    w_d_re  = 1'b1;
                    w_s_re  = 1'b1;
                    n_state = S_RUN_CMP;
                end
            end
            S_RUN_CMP: begin
                n_pos = w_pos_m1;
                if (!w_gt) begin
                    n_si    = w_si_m1;
                    n_pairs = r_pairs + 1'b1;
                end
                n_state = S_RUN_RD;
            end
            S_RUN_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out.match_count  = 9'(r_pairs);
                    n_out.load_dropped = r_ovf_run;
                    n_out_valid        = 1'b1;
                    n_state            = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_dcnt      <= '0;
            r_scnt      <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_dcnt      <= n_dcnt;
            r_scnt      <= n_scnt;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ovf_run <= n_ovf_run;
        r_sel     <= n_sel;
        r_pos     <= n_pos;
        r_si      <= n_si;
        r_pairs   <= n_pairs;
        r_val     <= n_val;
        r_out     <= n_out;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // a compare step only follows a read of real entries
    `GTMC_ASSERT_NOW(a_run_idx, i_clk, i_rst_n, r_state == S_RUN_CMP, r_pos != '0 && r_si != '0)
    `GTMC_ASSERT_NOW(a_ins_pos, i_clk, i_rst_n, r_state == S_INS_CMP, r_pos != '0)
    // a run leaves both lists empty and the flag clear
    `GTMC_ASSERT_NEXT(a_run_clr, i_clk, i_rst_n, w_acc && i_in.op == OP_RUN,
        r_dcnt == '0 && r_scnt == '0 && !r_ovf)
    // never more pairs than the list capacity
    `GTMC_ASSERT_NOW(a_pairs, i_clk, i_rst_n, r_state == S_RUN_OUT, r_pairs <= FULL)
endmodule
`default_nettype wire
